/* design/cmle_pkg.sv */
// shared types, codes and constants of the command mode escape and line editor
// no dependencies
package cmle_pkg;

  // line buffer depth default
  localparam int unsigned LINE_MAX_DEF = 16;

  // register map
  localparam int unsigned PADDR_W          = 3;
  localparam int unsigned PDATA_W          = 32;
  localparam logic        REG_GUARD_TICKS  = 1'b0;   // word index of guard_ticks
  localparam logic [7:0]  GUARD_RESET      = 8'd100;

  // field widths
  localparam int unsigned CHAR_W    = 7;
  localparam int unsigned CMD_LEN_W = 5;

  // input word kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_TICK = 2'd1;
  localparam logic [1:0] KIND_TAKE = 2'd2;

  // result character kinds
  localparam logic [1:0] CKIND_NONE = 2'd0;
  localparam logic [1:0] CKIND_ECHO = 2'd1;
  localparam logic [1:0] CKIND_CMD  = 2'd2;

  // characters
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [6:0] CH_LF7   = 7'h0A;
  localparam logic [6:0] CH_BS7   = 7'h08;
  localparam logic [6:0] CH_SP7   = 7'h20;
  localparam logic [6:0] CH_A7    = 7'h41;
  localparam logic [6:0] CH_T7    = 7'h54;

  // escape detector phases
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_PLUS1   = 3'd1;
  localparam logic [2:0] PH_PLUS2   = 3'd2;
  localparam logic [2:0] PH_PLUS3   = 3'd3;
  localparam logic [2:0] PH_CLOSING = 3'd4;

  // one result word
  typedef struct packed {
    logic [CMD_LEN_W-1:0] cmd_length;
    logic                 cmd_ready;
    logic                 mode_active;
    logic                 last;
    logic [1:0]           char_kind;
    logic [CHAR_W-1:0]    out_char;
  } out_word_t;

endpackage

/* design/cmle_line_mem.sv */
// line buffer memory: one write port, one read port, registered read data
// depends on nothing
module cmle_line_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 7,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* design/cmle_ctrl.sv */
// sequencer: escape detector, guard counter, line editor and command drain
// depends on cmle_pkg, drives the cmle_line_mem ports
module cmle_ctrl import cmle_pkg::*; #(
  parameter int unsigned LINE_MAX = LINE_MAX_DEF,
  parameter int unsigned AW       = $clog2(LINE_MAX),
  parameter int unsigned LW       = $clog2(LINE_MAX + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        guard_ticks_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        in_kind_i,
  input  logic [7:0]        in_byte_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_word_t         out_word_o,
  output logic              mem_we_o,
  output logic [AW-1:0]     mem_waddr_o,
  output logic [CHAR_W-1:0] mem_wdata_o,
  output logic [AW-1:0]     mem_raddr_o,
  input  logic [CHAR_W-1:0] mem_rdata_i
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ONE  = 3'd1;
  localparam logic [2:0] ST_BS3  = 3'd2;
  localparam logic [2:0] ST_TAKE = 3'd3;
  localparam logic [2:0] ST_AT   = 3'd4;

  localparam logic [LW-1:0] LEN_MAX = LW'(LINE_MAX);

  logic [2:0]        state_q, state_d;
  logic              mode_q, mode_d;
  logic              sub_q, sub_d;
  logic [2:0]        phase_q, phase_d;
  logic [7:0]        guard_q, guard_d;
  logic [LW-1:0]     len_q, len_d;
  logic [LW-1:0]     tlen_q, tlen_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic [CHAR_W-1:0] char_q, char_d;
  logic [1:0]        ckind_q, ckind_d;
  logic [1:0]        cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  out_word_t         out_q, out_d;

  logic              out_free;
  logic              accept;
  logic              take_last;
  logic [7:0]        guard_dec;
  logic [7:0]        up_char;

  assign out_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept    = in_valid_i && in_ready_o;
  assign take_last = ((LW'(idx_q) + LW'(1)) == tlen_q);
  assign guard_dec = guard_q - 8'd1;
  assign up_char   = ((in_byte_i >= 8'h61) && (in_byte_i <= 8'h7A)) ? (in_byte_i - 8'h20)
                                                                     : in_byte_i;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // result word with the status as it stands after the current item
  function automatic out_word_t make_word(logic [CHAR_W-1:0] ch, logic [1:0] kind,
                                          logic lst, logic mode, logic sub,
                                          logic [LW-1:0] len);
    out_word_t w;
    w.out_char    = ch;
    w.char_kind   = kind;
    w.last        = lst;
    w.mode_active = mode;
    w.cmd_ready   = sub;
    w.cmd_length  = CMD_LEN_W'(len);
    return w;
  endfunction

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    sub_d       = sub_q;
    phase_d     = phase_q;
    guard_d     = guard_q;
    len_d       = len_q;
    tlen_d      = tlen_q;
    idx_d       = idx_q;
    char_d      = char_q;
    ckind_d     = ckind_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = len_q[AW-1:0];
    mem_wdata_o = up_char[CHAR_W-1:0];
    mem_raddr_o = idx_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        mem_raddr_o = '0;
        if (accept) begin
          // a status word unless something below says otherwise
          state_d = ST_ONE;
          char_d  = '0;
          ckind_d = CKIND_NONE;
          unique case (in_kind_i)
            KIND_BYTE: begin
              if (mode_q) begin
                if (!sub_q) begin
                  if (in_byte_i == CH_CR) begin
                    char_d  = CH_LF7;
                    ckind_d = CKIND_ECHO;
                    sub_d   = 1'b1;
                  end else if ((in_byte_i == CH_BS) || (in_byte_i == CH_DEL)) begin
                    if (len_q != '0) begin
                      len_d   = len_q - LW'(1);
                      cnt_d   = 2'd0;
                      state_d = ST_BS3;
                    end
                  end else if (len_q < LEN_MAX) begin
                    if ((in_byte_i >= 8'h20) && (in_byte_i <= 8'h7E)) begin
                      mem_we_o = 1'b1;
                      len_d    = len_q + LW'(1);
                      char_d   = up_char[CHAR_W-1:0];
                      ckind_d  = CKIND_ECHO;
                    end
                  end else begin
                    // overflow drops back to data mode
                    mode_d = 1'b0;
                    len_d  = '0;
                  end
                end
              end else begin
                if (in_byte_i != CH_PLUS) begin
                  phase_d = PH_IDLE;
                  guard_d = guard_ticks_i;
                end else if ((phase_q == PH_PLUS1) || (phase_q == PH_PLUS2)) begin
                  phase_d = phase_q + 3'd1;
                end else if (phase_q == PH_PLUS3) begin
                  phase_d = PH_CLOSING;
                  guard_d = guard_ticks_i;
                end else begin
                  phase_d = PH_IDLE;
                  guard_d = guard_ticks_i;
                end
              end
            end
            KIND_TICK: begin
              if (guard_q != 8'd0) begin
                guard_d = guard_dec;
                if (guard_dec == 8'd0) begin
                  if (phase_q == PH_CLOSING) begin
                    mode_d      = 1'b1;
                    phase_d     = PH_IDLE;
                    sub_d       = 1'b1;
                    len_d       = LW'(2);
                    mem_we_o    = 1'b1;
                    mem_waddr_o = '0;
                    mem_wdata_o = CH_A7;
                    state_d     = ST_AT;
                  end else if ((phase_q == PH_IDLE) || (phase_q > PH_CLOSING)) begin
                    phase_d = PH_PLUS1;
                  end
                end
              end
            end
            KIND_TAKE: begin
              if (sub_q) begin
                if (len_q != '0) begin
                  tlen_d  = len_q;
                  idx_d   = '0;
                  state_d = ST_TAKE;
                end
                len_d = '0;
                sub_d = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_ONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = make_word(char_q, ckind_q, 1'b1, mode_q, sub_q, len_q);
          state_d     = ST_IDLE;
        end
      end

      ST_BS3: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = make_word((cnt_q == 2'd1) ? CH_SP7 : CH_BS7, CKIND_ECHO,
                                  cnt_q == 2'd2, mode_q, sub_q, len_q);
          cnt_d       = cnt_q + 2'd1;
          if (cnt_q == 2'd2) begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_TAKE: begin
        // read data belongs to idx_q; the next address is read while this one goes out
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = make_word(mem_rdata_i, CKIND_CMD, take_last, mode_q, sub_q, len_q);
          if (take_last) begin
            idx_d   = '0;
            state_d = ST_IDLE;
          end else begin
            idx_d       = idx_q + AW'(1);
            mem_raddr_o = idx_q + AW'(1);
          end
        end
      end

      ST_AT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = AW'(1);
        mem_wdata_o = CH_T7;
        state_d     = ST_ONE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= 1'b0;
      sub_q       <= 1'b0;
      phase_q     <= PH_IDLE;
      guard_q     <= GUARD_RESET;
      len_q       <= '0;
      idx_q       <= '0;
      cnt_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      sub_q       <= sub_d;
      phase_q     <= phase_d;
      guard_q     <= guard_d;
      len_q       <= len_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tlen_q  <= tlen_d;
    char_q  <= char_d;
    ckind_q <= ckind_d;
    out_q   <= out_d;
  end

endmodule

/* design/command_mode_escape_and_line_editor_unit.sv */
// top level of the command mode escape detector and line editor
// depends on cmle_pkg, cmle_line_mem and cmle_ctrl
//
// usage
//   input words arrive on the s_axis group: tuser carries the kind (received
//   byte, timer tick, take command) and tdata the byte. result words leave on
//   the m_axis group: tuser carries the character kind, tlast marks the final
//   word of an input, tdata the character and the status
//   guard_ticks is written through the apb port while the block is idle
// timing
//   one input is worked on at a time; a word is accepted in the idle state
//   and its first result is loaded into the result register by the state it
//   leads to, an escape completion first writing the second preloaded character
//   the input is freed once the last result of a word is loaded; an erase
//   loads backspace, space and backspace, an escape completion its status word
//   a command drain sends one character per cycle while m_axis_tready_i is high,
//   its synchronous read port reading the next line memory entry while one is sent
// reset
//   data mode, empty line, escape detector waiting for idle, guard count 100
// stall
//   the result register holds its word while m_axis_tready_i is low, and the
//   sequencer waits with it; no result is ever lost
module command_mode_escape_and_line_editor_unit import cmle_pkg::*; #(
  parameter int unsigned LINE_MAX = LINE_MAX_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input words
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [7:0]         s_axis_tdata_i,   // [7:0] byte_value
  input  logic [1:0]         s_axis_tuser_i,   // [1:0] kind
  // result words
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [15:0]        m_axis_tdata_o,   // [6:0] out_char, [7] mode_active,
                                               // [8] cmd_ready, [13:9] cmd_length, zero above
  output logic [1:0]         m_axis_tuser_o,   // [1:0] char_kind
  output logic               m_axis_tlast_o,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int unsigned AW = $clog2(LINE_MAX);
  localparam int unsigned LW = $clog2(LINE_MAX + 1);

  logic [7:0]        guard_ticks_q;
  logic              cfg_write;
  logic              reg_hit;
  out_word_t         out_word;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CHAR_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [CHAR_W-1:0] mem_rdata;

  // register file: a single word, byte offsets within it ignored
  assign pready    = 1'b1;
  assign reg_hit   = (paddr[PADDR_W-1] == REG_GUARD_TICKS);
  assign cfg_write = psel && penable && pwrite && pready && reg_hit;
  assign prdata    = reg_hit ? PDATA_W'(guard_ticks_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      guard_ticks_q <= GUARD_RESET;
    end else if (cfg_write) begin
      guard_ticks_q <= pwdata[7:0];
    end
  end

  cmle_ctrl #(
    .LINE_MAX (LINE_MAX),
    .AW       (AW),
    .LW       (LW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .guard_ticks_i (guard_ticks_q),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .in_kind_i     (s_axis_tuser_i),
    .in_byte_i     (s_axis_tdata_i),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_word_o    (out_word),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata)
  );

  // line buffer, contents undefined until written
  cmle_line_mem #(
    .DEPTH (LINE_MAX),
    .WIDTH (CHAR_W),
    .AW    (AW)
  ) u_line_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // pack the result word onto the stream
  assign m_axis_tdata_o = {2'b00, out_word.cmd_length, out_word.cmd_ready,
                           out_word.mode_active, out_word.out_char};
  assign m_axis_tuser_o = out_word.char_kind;
  assign m_axis_tlast_o = out_word.last;

endmodule

/* tb/sv/command_mode_escape_and_line_editor_unit_test.sv */
`timescale 1ns / 100ps
// self-checking testbench of command_mode_escape_and_line_editor_unit: stimulus, a line
// editor and escape detector predictor, and a result checker on the stream ports
// depends on cmle_pkg and the design sources
module command_mode_escape_and_line_editor_unit_test;
  import cmle_pkg::*;

  localparam int unsigned LINE_LEN    = LINE_MAX_DEF;
  localparam int unsigned CYCLE_LIMIT = 800_000;
  localparam int unsigned REPORT_CAP  = 60;
  // once the last awaited word is in, the block is already idle; a margin on top
  localparam int unsigned SETTLE_CYC  = 12;
  localparam int unsigned N_PHASES    = 5;

  localparam logic [1:0] KIND_SPARE = 2'd3;   // unused kind, answered with a status word only
  localparam logic [7:0] PRINT_LO   = 8'h20;
  localparam logic [7:0] PRINT_HI   = 8'h7E;
  localparam logic [7:0] LOWER_A    = 8'h61;
  localparam logic [7:0] LOWER_Z    = 8'h7A;
  localparam logic [7:0] CASE_GAP   = 8'h20;

  localparam logic [PADDR_W-1:0] GUARD_ADDR = PADDR_W'({REG_GUARD_TICKS, 2'b00});

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
  } in_word_t;

  // clock, reset and ports
  logic               clk      = 1'b0;
  logic               rst_n    = 1'b0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [7:0]         s_tdata  = '0;   // [7:0] byte_value
  logic [1:0]         s_tuser  = '0;   // [1:0] kind
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [15:0]        m_tdata;         // [6:0] out_char, [7] mode_active, [8] cmd_ready,
                                       // [13:9] cmd_length, zero above
  logic [1:0]         m_tuser;         // [1:0] char_kind
  logic               m_tlast;
  logic               psel     = 1'b0;
  logic               penable  = 1'b0;
  logic               pwrite   = 1'b0;
  logic [PADDR_W-1:0] paddr    = '0;
  logic [PDATA_W-1:0] pwdata   = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  always #5 clk = ~clk;

  command_mode_escape_and_line_editor_unit #(
    .LINE_MAX (LINE_LEN)
  ) u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // words waiting to be sent, and results the predictor has worked out
  in_word_t    in_words_pending[$];
  out_word_t   awaited_out_words[$];

  int unsigned words_queued    = 0;
  int unsigned words_issued    = 0;
  int unsigned words_taken     = 0;
  int unsigned results_checked = 0;
  int unsigned mismatch_count  = 0;
  int unsigned cycle_count     = 0;
  int unsigned escapes_seen    = 0;
  int unsigned overflows_seen  = 0;
  int unsigned drains_seen     = 0;

  // idling chances in percent, changed by the sequence between phases
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned src_gap      = 0;
  int unsigned snk_gap      = 0;

  // predictor copy of the block state and its register
  logic [6:0]  line_chars[LINE_LEN];
  logic [4:0]  line_len   = '0;
  logic        line_done  = 1'b0;
  logic        cmd_mode   = 1'b0;
  logic [2:0]  esc_phase  = PH_IDLE;
  logic [7:0]  guard_left = GUARD_RESET;
  logic [7:0]  guard_cfg  = GUARD_RESET;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatch_count < REPORT_CAP)
      $display("mismatch at result %0d: %s got 0x%0h, wanted 0x%0h",
               results_checked, what, got, want);
    mismatch_count++;
  endtask

  // works out every result word that one input word causes and queues them
  task automatic predict_editor_words(input logic [1:0] kind, input logic [7:0] b);
    logic [6:0] chars[$];
    logic [1:0] ckinds[$];
    logic [7:0] c;
    out_word_t  w;
    c = b;
    case (kind)
      KIND_BYTE: begin
        if (cmd_mode) begin
          // bytes are dropped while a submitted command waits to be taken
          if (!line_done) begin
            if (c == CH_CR) begin
              chars.push_back(CH_LF7);
              ckinds.push_back(CKIND_ECHO);
              line_done = 1'b1;
            end else if (c == CH_BS || c == CH_DEL) begin
              // erase echoes backspace, space, backspace; empty line is left alone
              if (line_len != 0) begin
                chars.push_back(CH_BS7);
                chars.push_back(CH_SP7);
                chars.push_back(CH_BS7);
                repeat (3) ckinds.push_back(CKIND_ECHO);
                line_len--;
              end
            end else if (line_len < LINE_LEN) begin
              if (c >= PRINT_LO && c <= PRINT_HI) begin
                if (c >= LOWER_A && c <= LOWER_Z) c = c - CASE_GAP;
                line_chars[line_len] = c[6:0];
                line_len++;
                chars.push_back(c[6:0]);
                ckinds.push_back(CKIND_ECHO);
              end
            end else begin
              // full line: anything but CR or an erase throws us back to data mode
              cmd_mode = 1'b0;
              line_len = '0;
              overflows_seen++;
            end
          end
        end else begin
          // escape detector
          if (c != CH_PLUS) begin
            esc_phase  = PH_IDLE;
            guard_left = guard_cfg;
          end else if (esc_phase == PH_PLUS1 || esc_phase == PH_PLUS2) begin
            esc_phase++;
          end else if (esc_phase == PH_PLUS3) begin
            esc_phase  = PH_CLOSING;
            guard_left = guard_cfg;
          end else begin
            // a mark with no quiet before it, or one inside the closing guard
            esc_phase  = PH_IDLE;
            guard_left = guard_cfg;
          end
        end
      end
      KIND_TICK: begin
        if (guard_left != 0) begin
          guard_left--;
          if (guard_left == 0) begin
            if (esc_phase == PH_CLOSING) begin
              // escape complete: command mode with the preloaded command
              cmd_mode      = 1'b1;
              esc_phase     = PH_IDLE;
              line_chars[0] = CH_A7;
              line_chars[1] = CH_T7;
              line_len      = 5'd2;
              line_done     = 1'b1;
              escapes_seen++;
            end else if (esc_phase == PH_IDLE || esc_phase > PH_CLOSING) begin
              esc_phase = PH_PLUS1;
            end
          end
        end
      end
      KIND_TAKE: begin
        if (line_done) begin
          for (int i = 0; i < line_len; i++) begin
            chars.push_back(line_chars[i]);
            ckinds.push_back(CKIND_CMD);
          end
          line_len  = '0;
          line_done = 1'b0;
          drains_seen++;
        end
      end
      default: ;
    endcase
    // an input with no character still gives one status word
    if (chars.size() == 0) begin
      chars.push_back('0);
      ckinds.push_back(CKIND_NONE);
    end
    for (int k = 0; k < chars.size(); k++) begin
      w.out_char    = chars[k];
      w.char_kind   = ckinds[k];
      w.last        = (k == chars.size() - 1);
      w.mode_active = cmd_mode;
      w.cmd_ready   = line_done;
      w.cmd_length  = line_len;
      awaited_out_words.push_back(w);
    end
  endtask

  task automatic check_out_word();
    out_word_t want;
    if (awaited_out_words.size() == 0) begin
      report_mismatch("word with none awaited, tdata", m_tdata, 0);
    end else begin
      want = awaited_out_words.pop_front();
      if (m_tdata[CHAR_W-1:0] !== want.out_char)
        report_mismatch("out_char", m_tdata[CHAR_W-1:0], want.out_char);
      if (m_tuser !== want.char_kind)
        report_mismatch("char_kind", m_tuser, want.char_kind);
      if (m_tlast !== want.last)
        report_mismatch("last", m_tlast, want.last);
      if (m_tdata[CHAR_W] !== want.mode_active)
        report_mismatch("mode_active", m_tdata[CHAR_W], want.mode_active);
      if (m_tdata[CHAR_W+1] !== want.cmd_ready)
        report_mismatch("cmd_ready", m_tdata[CHAR_W+1], want.cmd_ready);
      if (m_tdata[CHAR_W+2 +: CMD_LEN_W] !== want.cmd_length)
        report_mismatch("cmd_length", m_tdata[CHAR_W+2 +: CMD_LEN_W], want.cmd_length);
    end
    results_checked++;
  endtask

  // monitor: input acceptance feeds the predictor, result acceptance the checker
  always @(posedge clk) begin
    if (rst_n) begin
      if (s_tvalid && s_tready === 1'b1) begin
        predict_editor_words(s_tuser, s_tdata);
        words_taken++;
      end
      if (m_tvalid === 1'b1 && m_tready)
        check_out_word();
    end
  end

  // driver: a word stays up until taken, then the next one follows or a gap starts
  always @(negedge clk) begin
    in_word_t w;
    if (!rst_n) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && words_taken != words_issued) begin
      // still waiting for the handshake
    end else if (src_gap != 0) begin
      src_gap--;
      s_tvalid <= 1'b0;
    end else if (in_words_pending.size() != 0) begin
      if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
        src_gap = $urandom_range(1, 15) - 1;
        s_tvalid <= 1'b0;
      end else begin
        w = in_words_pending.pop_front();
        s_tuser  <= w.kind;
        s_tdata  <= w.value;
        s_tvalid <= 1'b1;
        words_issued++;
      end
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // result side back-pressure in bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      m_tready <= 1'b0;
    end else if (snk_gap != 0) begin
      snk_gap--;
      m_tready <= 1'b0;
    end else if (snk_idle_pct != 0 && $urandom_range(0, 99) < snk_idle_pct / 4) begin
      snk_gap = $urandom_range(1, 15) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("run stopped: timed out after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  // apb transfer: setup cycle, then access cycle completing when pready is high
  task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                            input logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_guard(input logic [7:0] v);
    logic [PDATA_W-1:0] rd;
    apb_access(1'b1, GUARD_ADDR, PDATA_W'(v), rd);
    guard_cfg = v;
    apb_access(1'b0, GUARD_ADDR, '0, rd);
    if (rd[7:0] !== v) report_mismatch("guard_ticks read back", rd[7:0], v);
  endtask

  // block idle: nothing left to send and every awaited word has arrived
  task automatic wait_for_drain();
    do begin
      @(posedge clk);
      #1;
    end while (in_words_pending.size() != 0 || words_taken != words_issued ||
               awaited_out_words.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic push_word(input logic [1:0] kind, input logic [7:0] value);
    in_word_t w;
    w.kind  = kind;
    w.value = value;
    in_words_pending.push_back(w);
    words_queued++;
  endtask

  task automatic push_byte(input logic [7:0] value);
    push_word(KIND_BYTE, value);
  endtask

  task automatic push_ticks(input int n);
    repeat (n) push_word(KIND_TICK, 8'($urandom_range(0, 255)));
  endtask

  function automatic logic [7:0] random_printable();
    return 8'($urandom_range(PRINT_LO, PRINT_HI));
  endfunction

  function automatic logic [7:0] random_non_plus();
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255)); while (v == CH_PLUS);
    return v;
  endfunction

  // mostly printable with some erases and the odd control or high byte
  function automatic logic [7:0] random_line_byte();
    int unsigned pick;
    logic [7:0]  v;
    pick = $urandom_range(0, 9);
    case (pick)
      7:       v = CH_BS;
      8:       v = CH_DEL;
      9:       begin
        do v = 8'($urandom_range(0, 255)); while (v == CH_CR);
      end
      default: v = random_printable();
    endcase
    return v;
  endfunction

  // an escape attempt: half well formed, half broken in one of several ways
  task automatic queue_escape(input int g);
    int unsigned pick;
    pick = $urandom_range(0, 9);
    push_byte(random_non_plus());
    if (pick == 4) begin
      // no quiet period before the marks
      repeat (3) push_byte(CH_PLUS);
      push_ticks(g + 1);
    end else begin
      push_ticks(g + $urandom_range(0, 2));
      case (pick)
        0: begin
          repeat (2) push_byte(CH_PLUS);
          push_ticks(g + 1);
        end
        1: begin
          push_byte(CH_PLUS);
          push_byte(random_non_plus());
          repeat (2) push_byte(CH_PLUS);
          push_ticks(g + 1);
        end
        2: begin
          // fourth mark inside the closing guard
          repeat (3) push_byte(CH_PLUS);
          push_ticks($urandom_range(0, g - 1));
          push_byte(CH_PLUS);
          push_ticks(g + 1);
        end
        3: begin
          // a byte just before the closing guard runs out
          repeat (3) push_byte(CH_PLUS);
          push_ticks(g - 1);
          push_byte(random_non_plus());
          push_ticks(g);
        end
        default: begin
          repeat (3) push_byte(CH_PLUS);
          push_ticks(g + $urandom_range(0, 1));
        end
      endcase
    end
  endtask

  // command mode work: a few edited lines, each submitted and taken, then mostly an overflow
  task automatic queue_lines();
    int unsigned n_lines;
    n_lines = $urandom_range(1, 3);
    repeat (n_lines) begin
      push_word(KIND_TAKE, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 4) == 0)
        repeat (LINE_LEN) push_byte(random_printable());
      else
        repeat ($urandom_range(0, 12)) push_byte(random_line_byte());
      push_byte(CH_CR);
      if ($urandom_range(0, 3) == 0) push_byte(random_line_byte());
    end
    push_word(KIND_TAKE, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 4) != 0) begin
      repeat (LINE_LEN) push_byte(random_printable());
      push_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic queue_noise();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 9)
      push_byte(($urandom_range(0, 3) == 0) ? CH_PLUS : 8'($urandom_range(0, 255)));
    else if (pick < 16)
      push_word(KIND_TICK, 8'($urandom_range(0, 255)));
    else if (pick < 19)
      push_word(KIND_TAKE, 8'($urandom_range(0, 255)));
    else
      push_word(KIND_SPARE, 8'($urandom_range(0, 255)));
  endtask

  task automatic queue_session(input int g);
    queue_escape(g);
    queue_lines();
    repeat ($urandom_range(0, 3)) queue_noise();
  endtask

  // test sequence
  initial begin
    logic [PDATA_W-1:0] rd;
    int unsigned        start;
    int unsigned        guard_plan[N_PHASES];
    int unsigned        budget_plan[N_PHASES];
    int unsigned        src_plan[N_PHASES];
    int unsigned        snk_plan[N_PHASES];

    guard_plan  = '{3, 255, 1, $urandom_range(4, 12), 2};
    budget_plan = '{95, 40, 85, 95, 75};
    src_plan    = '{30, 50, 0, 15, 0};
    snk_plan    = '{30, 10, 0, 50, 0};

    src_idle_pct = 25;
    snk_idle_pct = 25;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    apb_access(1'b0, GUARD_ADDR, '0, rd);
    if (rd[7:0] !== GUARD_RESET) report_mismatch("guard_ticks after reset", rd[7:0], GUARD_RESET);

    // data mode at the reset guard: byte extremes, nothing to take, the spare kind
    push_byte(8'h00);
    push_word(KIND_TICK, 8'hFF);
    push_word(KIND_TAKE, 8'h00);
    push_word(KIND_SPARE, 8'hFF);
    push_byte(8'hFF);
    wait_for_drain();

    // shortest guard: one clean escape, then each editing case but an overflow
    set_guard(8'd1);
    push_byte(8'h78);
    push_word(KIND_TICK, 8'h00);
    repeat (3) push_byte(CH_PLUS);
    push_word(KIND_TICK, 8'h00);
    push_byte(8'h7A);              // dropped, the preloaded command still waits
    push_word(KIND_TAKE, 8'h00);
    push_byte(LOWER_A);            // lower case comes back upper case
    push_byte(8'h62);
    push_byte(PRINT_HI);
    push_byte(CH_DEL);
    push_byte(CH_BS);
    push_byte(CH_BS);
    push_byte(CH_BS);              // erase on an empty line
    push_byte(8'h1F);
    push_byte(8'hFF);
    push_byte(PRINT_LO);
    push_byte(CH_CR);
    push_word(KIND_TAKE, 8'hFF);
    push_byte(CH_CR);              // empty command
    push_word(KIND_TAKE, 8'h00);
    wait_for_drain();

    // random phases over several guard settings; the last one runs without idling
    for (int p = 0; p < N_PHASES; p++) begin
      src_idle_pct = src_plan[p];
      snk_idle_pct = snk_plan[p];
      set_guard(8'(guard_plan[p]));
      start = words_queued;
      while (words_queued - start < budget_plan[p]) begin
        if (guard_plan[p] > 32) queue_noise();
        else queue_session(guard_plan[p]);
      end
      wait_for_drain();
    end

    $display("covered %0d input words and %0d result words over %0d guard settings",
             words_taken, results_checked, N_PHASES + 2);
    $display("%0d escapes into command mode, %0d line overflows, %0d commands drained",
             escapes_seen, overflows_seen, drains_seen);
    if (mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

/* filelist.f */
design/cmle_pkg.sv
design/cmle_line_mem.sv
design/cmle_ctrl.sv
design/command_mode_escape_and_line_editor_unit.sv
tb/sv/command_mode_escape_and_line_editor_unit_test.sv
